/* rtl/lppp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the range-scanner point plotter.
// No dependencies; imported by every other file in rtl/.
package lppp_pkg;

    // distance is in 1/40 cm, angle in 1/64 degree
    localparam int DIST_SCALE      = 40;
    localparam int ANGLE_FULL      = 23040;
    localparam int ANGLE_HALF      = 11520;
    localparam int ANGLE_QUARTER   = 5760;
    localparam int WRAP_LAST_ABOVE = 19200;
    localparam int WRAP_NEW_BELOW  = 640;
    localparam int CORDIC_GAIN_Q15 = 19899;

    localparam int ANG_W  = 16;          // folded angle, signed
    localparam int Z_W    = ANG_W + 10;  // residual angle in 1/65536 degree
    localparam int XY_W   = 18;          // CORDIC vector, headroom above Q1.15
    localparam int ATAN_W = 22;
    localparam int OFF_W  = 11;          // offset magnitude, 65535/40 at most
    localparam int POS_W  = 13;          // signed screen position before clipping

    typedef logic signed [15:0]    trig_t;
    typedef logic signed [OFF_W:0] offset_t;

    typedef struct packed {
        logic  done;
        trig_t sin_v;
        trig_t cos_v;
    } trig_res_t;

    typedef struct packed {
        logic    done;
        offset_t off_x;
        offset_t off_y;
    } offs_res_t;

    typedef enum logic [2:0] {
        CFG_MIN_DIST  = 3'd0,
        CFG_MAX_DIST  = 3'd1,
        CFG_SHOW_DIST = 3'd2,
        CFG_CENTRE_X  = 3'd3,
        CFG_CENTRE_Y  = 3'd4
    } cfg_reg_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/lidar_polar_point_plotter_unit.sv */
`timescale 1ns / 1ps
// Top level of the range-scanner point plotter: sample checks, revolution tracking, sequencer.
// Depends on lppp_pkg, lppp_cordic and lppp_scaler.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------------
//  in       | in_valid/in_ready   | raw_angle[14:0], raw_distance[15:0]
//  out      | out_valid/out_ready | clear_screen, plot_point, pixel_x[8:0], pixel_y[7:0]
//  cfg      | cfg_we (no wait)    | cfg_index[2:0], cfg_data[10:0]
//
// One sample at a time. A sample inside the distance window goes through the CORDIC (one
// rotation step per cycle) and then four passes through the single 16x17 multiplier of
// the scaler; one outside it goes straight to the output stage.
// The finished beat sits in the output register, so a stalled sink only holds the
// sequencer once the next result is ready. Asynchronous active-low reset; no clearing pass.
module lidar_polar_point_plotter_unit #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int CM_PER_PIXEL  = 2,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // sample input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [14:0] raw_angle,
    input  logic [15:0] raw_distance,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic        clear_screen,
    output logic        plot_point,
    output logic [8:0]  pixel_x,
    output logic [7:0]  pixel_y,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import lppp_pkg::*;

    // plot window, inclusive bounds
    localparam logic signed [POS_W-1:0] X_LO = POS_W'(1);
    localparam logic signed [POS_W-1:0] X_HI = POS_W'(SCREEN_WIDTH - 2);
    localparam logic signed [POS_W-1:0] Y_LO = POS_W'(1);
    localparam logic signed [POS_W-1:0] Y_HI = POS_W'(SCREEN_HEIGHT - 2);

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,   // waiting for a sample
        T_TRIG  = 5'b00010,   // CORDIC running
        T_SCALE = 5'b00100,   // offsets being scaled
        T_PLACE = 5'b01000,   // position and clip
        T_OUT   = 5'b10000    // waiting for room in the output register
    } top_state_t;

    // distance in cm to the 1/40 cm units of the sample, as shifts and an add
    function automatic logic [16:0] times40(input logic [10:0] v);
        return ({6'b0, v} << 5) + ({6'b0, v} << 3);
    endfunction

    top_state_t  state_reg;

    // configuration
    logic [10:0] min_dist_reg, max_dist_reg, show_dist_reg;
    logic [8:0]  centre_x_reg;
    logic [7:0]  centre_y_reg;

    // revolution tracking
    logic [14:0] last_angle_reg;
    logic        no_angle_yet_reg;

    // per-sample working registers
    logic [15:0] dist_reg;
    logic        clear_reg;
    logic        show_ok_reg;
    logic        res_plot_reg;
    logic [8:0]  res_x_reg;
    logic [7:0]  res_y_reg;

    // output register
    logic        out_valid_reg;
    logic        clear_screen_reg, plot_point_reg;
    logic [8:0]  pixel_x_reg;
    logic [7:0]  pixel_y_reg;

    logic        in_fire, out_fire, out_load;
    logic        in_window, wrap_hit;
    logic        trig_start, scale_start;
    trig_res_t   trig;
    offs_res_t   offs;
    logic signed [POS_W-1:0] px, py;
    logic        plot_ok;

    assign in_ready = (state_reg == T_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_load = (state_reg == T_OUT) && (!out_valid_reg || out_ready);

    // window and wrap tests on the raw, unreduced values
    assign in_window = !(({1'b0, raw_distance} < times40(min_dist_reg)) ||
                         ({1'b0, raw_distance} > times40(max_dist_reg)));
    assign wrap_hit  = ((last_angle_reg > 15'(WRAP_LAST_ABOVE)) &&
                        (raw_angle < 15'(WRAP_NEW_BELOW))) || no_angle_yet_reg;

    assign trig_start  = in_fire && in_window;
    assign scale_start = (state_reg == T_TRIG) && trig.done;

    lppp_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (raw_angle),
        .res   (trig)
    );

    lppp_scaler #(
        .CM_PER_PIXEL (CM_PER_PIXEL)
    ) u_scaler (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scale_start),
        .distance (dist_reg),
        .sin_v    (trig.sin_v),
        .cos_v    (trig.cos_v),
        .res      (offs)
    );

    // 0 degrees points up the screen, so y runs against the cosine
    assign px = $signed({4'b0, centre_x_reg}) + POS_W'(offs.off_x);
    assign py = $signed({5'b0, centre_y_reg}) - POS_W'(offs.off_y);
    assign plot_ok = show_ok_reg && (px >= X_LO) && (px <= X_HI) &&
                     (py >= Y_LO) && (py <= Y_HI);

    // configuration port; unknown indices are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg  <= 11'd5;
            max_dist_reg  <= 11'd500;
            show_dist_reg <= 11'd100;
            centre_x_reg  <= 9'd160;
            centre_y_reg  <= 8'd120;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_DIST:  min_dist_reg  <= cfg_data;
                CFG_MAX_DIST:  max_dist_reg  <= cfg_data;
                CFG_SHOW_DIST: show_dist_reg <= cfg_data;
                CFG_CENTRE_X:  centre_x_reg  <= cfg_data[8:0];
                CFG_CENTRE_Y:  centre_y_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer, revolution state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            last_angle_reg   <= '0;
            no_angle_yet_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_fire)
                    begin
                        // every sample, in window or not, moves the stored angle on
                        last_angle_reg   <= raw_angle;
                        no_angle_yet_reg <= 1'b0;
                        state_reg        <= in_window ? T_TRIG : T_OUT;
                    end
                end
                T_TRIG:  if (trig.done) state_reg <= T_SCALE;
                T_SCALE: if (offs.done) state_reg <= T_PLACE;
                T_PLACE: state_reg <= T_OUT;
                T_OUT:   if (out_load) state_reg <= T_IDLE;
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dist_reg     <= raw_distance;
            clear_reg    <= in_window && wrap_hit;
            res_plot_reg <= 1'b0;
            res_x_reg    <= '0;
            res_y_reg    <= '0;
        end
        if (state_reg == T_TRIG)
            show_ok_reg <= ({1'b0, dist_reg} <= times40(show_dist_reg));
        if (state_reg == T_PLACE)
        begin
            res_plot_reg <= plot_ok;
            res_x_reg    <= plot_ok ? px[8:0] : '0;
            res_y_reg    <= plot_ok ? py[7:0] : '0;
        end
        if (out_load)
        begin
            clear_screen_reg <= clear_reg;
            plot_point_reg   <= res_plot_reg;
            pixel_x_reg      <= res_x_reg;
            pixel_y_reg      <= res_y_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign clear_screen = clear_screen_reg;
    assign plot_point   = plot_point_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("sequencer ready straight after taking a sample");

    a_trig_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        trig.done |-> state_reg == T_TRIG)
        else $error("CORDIC finished outside the trig phase");

    a_scale_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        offs.done |-> state_reg == T_SCALE)
        else $error("scaler finished outside the scale phase");

    a_blank_when_unplotted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !plot_point) |-> (pixel_x == '0 && pixel_y == '0))
        else $error("pixel coordinates set on a beat with no plot");

endmodule

/* rtl/lppp_cordic.sv */
`timescale 1ns / 1ps
// Iterative rotation CORDIC: one shift/add/sub step per cycle, sine and cosine in Q1.15.
// Depends on lppp_pkg.
module lppp_cordic #(
    parameter int STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [14:0]        angle,
    output lppp_pkg::trig_res_t res
);
    import lppp_pkg::*;

    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_FOLD = 4'b0010,
        C_ITER = 4'b0100,
        C_SAT  = 4'b1000
    } cordic_state_t;

    cordic_state_t            phase_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [ANG_W-1:0]  a_reg;
    logic                     neg_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    trig_t                    sin_reg, cos_reg;
    logic                     done_reg;

    logic signed [ANG_W-1:0]  ang_ext, a_half, a_fold;
    logic                     fold_neg;
    logic [4:0]               sh;
    logic signed [Z_W-1:0]    atan_v;
    logic signed [XY_W-1:0]   x_sh, y_sh, x_next, y_next, xn, yn;
    logic signed [Z_W-1:0]    z_next;

    // reduce modulo a full turn and into (-180, 180] in one compare
    assign ang_ext = $signed({1'b0, angle});
    assign a_half  = (ang_ext > ANG_W'(ANGLE_HALF)) ? ang_ext - ANG_W'(ANGLE_FULL) : ang_ext;

    always_comb
    begin
        fold_neg = 1'b0;
        a_fold   = a_reg;
        if (a_reg > ANG_W'(ANGLE_QUARTER))
        begin
            a_fold   = a_reg - ANG_W'(ANGLE_HALF);
            fold_neg = 1'b1;
        end
        else if (a_reg < -ANG_W'(ANGLE_QUARTER))
        begin
            a_fold   = a_reg + ANG_W'(ANGLE_HALF);
            fold_neg = 1'b1;
        end
    end

    // the shared step
    assign sh     = 5'(step_reg);
    assign atan_v = $signed(Z_W'(atan_lut(sh)));
    assign x_sh   = x_reg >>> sh;
    assign y_sh   = y_reg >>> sh;

    always_comb
    begin
        if (z_reg >= 0)
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan_v;
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan_v;
        end
    end

    assign xn = neg_reg ? -x_reg : x_reg;
    assign yn = neg_reg ? -y_reg : y_reg;

    function automatic trig_t sat_q15(input logic signed [XY_W-1:0] v);
        trig_t r;
        if (v > XY_W'(32767))
            r = 16'sh7FFF;
        else if (v < -XY_W'(32768))
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= C_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                C_IDLE:
                begin
                    if (start)
                        phase_reg <= C_FOLD;
                end
                C_FOLD:
                begin
                    step_reg  <= '0;
                    phase_reg <= C_ITER;
                end
                C_ITER:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        phase_reg <= C_SAT;
                end
                C_SAT:
                begin
                    done_reg  <= 1'b1;
                    phase_reg <= C_IDLE;
                end
                default: phase_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == C_IDLE && start)
            a_reg <= a_half;
        if (phase_reg == C_FOLD)
        begin
            neg_reg <= fold_neg;
            z_reg   <= $signed({a_fold, 10'b0});
            x_reg   <= XY_W'(CORDIC_GAIN_Q15);
            y_reg   <= '0;
        end
        if (phase_reg == C_ITER)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (phase_reg == C_SAT)
        begin
            cos_reg <= sat_q15(xn);
            sin_reg <= sat_q15(yn);
        end
    end

    assign res.done  = done_reg;
    assign res.sin_v = sin_reg;
    assign res.cos_v = cos_reg;

endmodule

/* rtl/lppp_scaler.sv */
`timescale 1ns / 1ps
// Turns distance and sine/cosine into signed pixel offsets on one shared multiplier.
// Division by the scale uses a reciprocal product. Depends on lppp_pkg.
module lppp_scaler #(
    parameter int CM_PER_PIXEL = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         distance,
    input  lppp_pkg::trig_t     sin_v,
    input  lppp_pkg::trig_t     cos_v,
    output lppp_pkg::offs_res_t res
);
    import lppp_pkg::*;

    // exact floor(p / DIV) for any 16-bit p: ceil(2^SHIFT / DIV) with SHIFT = 16 + clog2(DIV)
    localparam int DIV   = DIST_SCALE * CM_PER_PIXEL;
    localparam int SHIFT = 16 + $clog2(DIV);
    localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [16:0] RECIP = RECIP_WIDE[16:0];

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL_S = 6'b000010,
        S_REC_S = 6'b000100,
        S_MUL_C = 6'b001000,
        S_REC_C = 6'b010000,
        S_DONE  = 6'b100000
    } scale_state_t;

    scale_state_t  phase_reg;
    logic          done_reg;
    logic [15:0]   dist_reg;
    logic [16:0]   mag_s_reg, mag_c_reg;
    logic          neg_s_reg, neg_c_reg;
    logic [32:0]   prod_reg;
    offset_t       off_x_reg, off_y_reg;

    logic signed [16:0] s_ext, c_ext;
    logic [15:0]   mul_a;
    logic [16:0]   mul_b;
    logic [32:0]   prod_next;
    logic [OFF_W-1:0] quot;
    offset_t       q_pos;

    assign s_ext = {sin_v[15], sin_v};
    assign c_ext = {cos_v[15], cos_v};

    // operand select for the single multiplier
    always_comb
    begin
        mul_a = prod_reg[30:15];
        mul_b = RECIP;
        case (phase_reg)
            S_MUL_S:
            begin
                mul_a = dist_reg;
                mul_b = mag_s_reg;
            end
            S_MUL_C:
            begin
                mul_a = dist_reg;
                mul_b = mag_c_reg;
            end
            default:
            begin
                mul_a = prod_reg[30:15];
                mul_b = RECIP;
            end
        endcase
    end

    assign prod_next = {17'b0, mul_a} * {16'b0, mul_b};
    assign quot      = OFF_W'(prod_reg >> SHIFT);
    assign q_pos     = $signed({1'b0, quot});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                S_IDLE:  if (start) phase_reg <= S_MUL_S;
                S_MUL_S: phase_reg <= S_REC_S;
                S_REC_S: phase_reg <= S_MUL_C;
                S_MUL_C: phase_reg <= S_REC_C;
                S_REC_C: phase_reg <= S_DONE;
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    phase_reg <= S_IDLE;
                end
                default: phase_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == S_IDLE && start)
        begin
            dist_reg  <= distance;
            mag_s_reg <= 17'(s_ext[16] ? -s_ext : s_ext);
            mag_c_reg <= 17'(c_ext[16] ? -c_ext : c_ext);
            neg_s_reg <= s_ext[16];
            neg_c_reg <= c_ext[16];
        end
        if (phase_reg != S_IDLE && phase_reg != S_DONE)
            prod_reg <= prod_next;
        if (phase_reg == S_MUL_C)
            off_x_reg <= neg_s_reg ? -q_pos : q_pos;
        if (phase_reg == S_DONE)
            off_y_reg <= neg_c_reg ? -q_pos : q_pos;
    end

    assign res.done  = done_reg;
    assign res.off_x = off_x_reg;
    assign res.off_y = off_y_reg;

endmodule

/* sim/lidar_polar_point_plotter_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for lidar_polar_point_plotter_unit: directed samples, then random scans.
// Depends on rtl/lppp_pkg.sv and rtl/lidar_polar_point_plotter_unit.sv.
module lidar_polar_point_plotter_unit_tb;
    import lppp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int SCREEN_W     = 320;
    localparam int SCREEN_H     = 240;
    localparam int PIXEL_CM     = 2;
    localparam int ROT_STEPS    = 16;
    localparam int SETTLE       = 40;        // a little over one sample's worth of CORDIC + scaler
    localparam int HOLD_CYCLES  = 400;       // long sink hold-off
    localparam int RUN_LIMIT_NS = 8_000_000; // several times the slowest clean run
    localparam int PRINT_CAP    = 100;

    // indexes with no register behind them
    localparam int CFG_SPARE_LO = 5;
    localparam int CFG_SPARE_HI = 7;

    // atan(2^-i) in 1/65536 degree
    localparam int ROT_ANGLE [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic       clear_screen;
        logic       plot_point;
        logic [8:0] pixel_x;
        logic [7:0] pixel_y;
    } plot_beat_t;

    localparam plot_beat_t QUIET = '{1'b0, 1'b0, 9'd0, 8'd0};

    typedef struct packed {
        logic [14:0] ang;
        logic [15:0] distance;
        logic        typed;   // expectation written in the row rather than predicted
        plot_beat_t  want;
    } sample_row_t;

    // Directed samples at reset settings: min 5 cm, max 500 cm, show 100 cm, centre 160/120.
    // Distances are in 1/40 cm, so the window is 200..20000 and the show limit 4000.
    localparam int N_ROWS = 25;
    localparam sample_row_t DIRECTED [N_ROWS] = '{
        '{15'd0,     16'd2000,  1'b0, QUIET},  // first sample ever: clear
        '{15'd5760,  16'd4000,  1'b0, QUIET},  // 90 degrees
        '{15'd11520, 16'd4000,  1'b0, QUIET},  // 180 degrees
        '{15'd17280, 16'd4000,  1'b0, QUIET},  // 270 degrees
        '{15'd19201, 16'd0,     1'b1, QUIET},  // too near: angle stored only
        '{15'd639,   16'd2000,  1'b0, QUIET},  // wrap past zero: clear
        '{15'd19200, 16'd2000,  1'b0, QUIET},
        '{15'd100,   16'd2000,  1'b0, QUIET},  // last exactly 300 deg: no wrap
        '{15'd32767, 16'd65535, 1'b1, QUIET},  // both fields at top, too far
        '{15'd0,     16'd199,   1'b1, QUIET},  // one under minimum
        '{15'd0,     16'd200,   1'b0, QUIET},  // exactly minimum
        '{15'd0,     16'd20000, 1'b1, QUIET},  // exactly maximum, beyond show
        '{15'd0,     16'd20001, 1'b1, QUIET},  // one over maximum
        '{15'd0,     16'd4000,  1'b0, QUIET},  // exactly show limit
        '{15'd0,     16'd4001,  1'b1, QUIET},  // one over show limit
        '{15'd23040, 16'd3000,  1'b0, QUIET},  // 360 deg, unreduced
        '{15'd23039, 16'd3000,  1'b0, QUIET},
        '{15'd5761,  16'd3000,  1'b0, QUIET},  // just past a quarter: folded
        '{15'd17279, 16'd3000,  1'b0, QUIET},
        '{15'd11521, 16'd3000,  1'b0, QUIET},  // just past half
        '{15'd2880,  16'd4000,  1'b0, QUIET},  // 45 degrees
        '{15'd32767, 16'd4000,  1'b0, QUIET},  // top angle, valid, no wrap
        '{15'd16384, 16'd4000,  1'b0, QUIET},
        '{15'd21000, 16'd100,   1'b1, QUIET},  // too near, stores a high angle
        '{15'd0,     16'd1000,  1'b0, QUIET}   // wrap seen through the stored angle
    };

    // ---------------------------------------------------------------- DUT hookup
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [14:0] raw_angle    = '0;
    logic [15:0] raw_distance = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        clear_screen;
    logic        plot_point;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        cfg_we       = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [10:0] cfg_data     = '0;

    lidar_polar_point_plotter_unit #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H),
        .CM_PER_PIXEL  (PIXEL_CM),
        .CORDIC_STEPS  (ROT_STEPS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_angle    (raw_angle),
        .raw_distance (raw_distance),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .clear_screen (clear_screen),
        .plot_point   (plot_point),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------- predictor state
    // Register copies, masked to their widths just as the block masks them.
    logic [10:0] min_cm  = 11'd5;
    logic [10:0] max_cm  = 11'd500;
    logic [10:0] show_cm = 11'd100;
    logic [8:0]  org_x   = 9'd160;
    logic [7:0]  org_y   = 8'd120;
    // scan tracking
    logic [14:0] last_ang      = '0;
    logic        no_sample_yet = 1'b1;

    plot_beat_t pending_pixels [$];   // beats still owed by the block, oldest first
    plot_beat_t head_beat;
    int         mismatches  = 0;
    int         beats_seen  = 0;
    int         sweep_base  = 0;
    bit         hold_req    = 1'b0;   // sender asks the sink for a long hold-off
    bit         sink_stalls = 1'b1;

    function automatic int clamp_q15(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Rotation-mode CORDIC, sin and cos in Q1.15. Angle folded into +-90 deg first;
    // >>> on int floors, which is the rounding the block uses for negative shifts.
    function automatic void cordic_trig(input int ang, output int sin_q15, output int cos_q15);
        int a;
        int xv;
        int yv;
        int zv;
        int tv;
        bit flip;
        a    = ang % ANGLE_FULL;
        flip = 1'b0;
        if (a > ANGLE_HALF)
            a -= ANGLE_FULL;
        if (a > ANGLE_QUARTER)
        begin
            a -= ANGLE_HALF;
            flip = 1'b1;
        end
        else if (a < -ANGLE_QUARTER)
        begin
            a += ANGLE_HALF;
            flip = 1'b1;
        end
        xv = CORDIC_GAIN_Q15;
        yv = 0;
        zv = a * 1024;
        for (int i = 0; i < ROT_STEPS && i < 24; i++)
        begin
            if (zv >= 0)
            begin
                tv = xv - (yv >>> i);
                yv = yv + (xv >>> i);
                zv -= ROT_ANGLE[i];
            end
            else
            begin
                tv = xv + (yv >>> i);
                yv = yv - (xv >>> i);
                zv += ROT_ANGLE[i];
            end
            xv = tv;
        end
        if (flip)
        begin
            xv = -xv;
            yv = -yv;
        end
        cos_q15 = clamp_q15(xv);
        sin_q15 = clamp_q15(yv);
    endfunction

    // distance * trig / (40 * cm-per-pixel * 2^15), truncated toward zero
    function automatic longint pixel_offset(input int distance, input int trig);
        longint mag;
        longint q;
        mag = (trig < 0) ? -longint'(trig) : longint'(trig);
        q   = (longint'(distance) * mag) / (longint'(DIST_SCALE) * PIXEL_CM * 32768);
        return (trig < 0) ? -q : q;
    endfunction

    // Works out the beat for one accepted sample and advances the scan tracking.
    function automatic plot_beat_t plot_sample(input logic [14:0] ang,
                                               input logic [15:0] distance);
        plot_beat_t beat;
        bit         wrapped;
        int         s;
        int         c;
        longint     px;
        longint     py;
        beat = QUIET;
        if (int'(distance) < DIST_SCALE * int'(min_cm) ||
            int'(distance) > DIST_SCALE * int'(max_cm))
        begin
            last_ang      = ang;
            no_sample_yet = 1'b0;
            return beat;
        end
        wrapped = (int'(last_ang) > WRAP_LAST_ABOVE) && (int'(ang) < WRAP_NEW_BELOW);
        beat.clear_screen = wrapped || no_sample_yet;
        last_ang      = ang;
        no_sample_yet = 1'b0;

        cordic_trig(int'(ang), s, c);
        px = longint'(org_x) + pixel_offset(int'(distance), s);
        py = longint'(org_y) - pixel_offset(int'(distance), c);
        if (int'(distance) <= DIST_SCALE * int'(show_cm) &&
            px >= 1 && px < SCREEN_W - 1 && py >= 1 && py < SCREEN_H - 1)
        begin
            beat.plot_point = 1'b1;
            beat.pixel_x    = px[8:0];
            beat.pixel_y    = py[7:0];
        end
        return beat;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("%0t: beat %0d %s: got %0d, expected %0d", $time, beats_seen, what, got,
                     want);
        mismatches++;
    endtask

    // Output beats are sampled at the edge that takes them; values seen are pre-edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
                note_mismatch("beat with nothing due", 1, 0);
            else
            begin
                head_beat = pending_pixels.pop_front();
                if (clear_screen !== head_beat.clear_screen)
                    note_mismatch("clear_screen", clear_screen, head_beat.clear_screen);
                if (plot_point !== head_beat.plot_point)
                    note_mismatch("plot_point", plot_point, head_beat.plot_point);
                if (pixel_x !== head_beat.pixel_x)
                    note_mismatch("pixel_x", pixel_x, head_beat.pixel_x);
                if (pixel_y !== head_beat.pixel_y)
                    note_mismatch("pixel_y", pixel_y, head_beat.pixel_y);
            end
            beats_seen++;
        end
    end

    // ---------------------------------------------------------------- stimulus helpers
    // Presents one sample and holds it until taken. Valid is left high on return so a
    // following sample can go straight out on the next edge.
    task automatic offer_sample(input logic [14:0] ang, input logic [15:0] distance,
                                input logic typed, input plot_beat_t want);
        plot_beat_t due;
        in_valid     <= 1'b1;
        raw_angle    <= ang;
        raw_distance <= distance;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        due = plot_sample(ang, distance);
        pending_pixels.push_back(typed ? want : due);
    endtask

    // Stop offering, wait for every owed beat, then let the pipeline settle.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write per edge; cfg_we is lowered by the caller after the last one.
    task automatic cfg_write(input logic [2:0] idx, input logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_MIN_DIST:  min_cm  = val;
            CFG_MAX_DIST:  max_cm  = val;
            CFG_SHOW_DIST: show_cm = val;
            CFG_CENTRE_X:  org_x   = val[8:0];
            CFG_CENTRE_Y:  org_y   = val[7:0];
            default:       ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input int phase);
        case (phase)
            0:
            begin
                // min and centres at the bottom, max and show at the top: wide-open window
                cfg_write(CFG_MIN_DIST, 11'd0);
                cfg_write(CFG_MAX_DIST, 11'd2047);
                cfg_write(CFG_SHOW_DIST, 11'd2047);
                cfg_write(CFG_CENTRE_X, 11'd0);
                cfg_write(CFG_CENTRE_Y, 11'd0);
            end
            1:
            begin
                // all ones but max (zero); centre writes get masked, and nothing is in range
                cfg_write(CFG_MIN_DIST, 11'd2047);
                cfg_write(CFG_MAX_DIST, 11'd0);
                cfg_write(CFG_SHOW_DIST, 11'd2047);
                cfg_write(CFG_CENTRE_X, 11'd2047);
                cfg_write(CFG_CENTRE_Y, 11'd2047);
            end
            2:
            begin
                cfg_write(CFG_MIN_DIST, 11'd1638);
                cfg_write(CFG_MAX_DIST, 11'd1638);
                cfg_write(CFG_SHOW_DIST, 11'd1638);
                cfg_write(CFG_CENTRE_X, 11'd319);
                cfg_write(CFG_CENTRE_Y, 11'd239);
            end
            default:
            begin
                cfg_write(CFG_MIN_DIST, 11'($urandom_range(0, 60)));
                cfg_write(CFG_MAX_DIST, 11'($urandom_range(100, 1638)));
                cfg_write(CFG_SHOW_DIST, 11'($urandom_range(0, 300)));
                cfg_write(CFG_CENTRE_X, 11'($urandom_range(0, 319)));
                cfg_write(CFG_CENTRE_Y, 11'($urandom_range(0, 239)));
            end
        endcase
        // unmapped indexes must leave everything alone
        if (phase == 5)
            for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++)
                cfg_write(3'(i), 11'($urandom_range(0, 2047)));
        cfg_we <= 1'b0;
    endtask

    // Scan-like angle: steady forward steps with wrap, now and then the unreduced alias.
    function automatic logic [14:0] sweep_angle();
        sweep_base += $urandom_range(1, 400);
        if (sweep_base >= ANGLE_FULL)
            sweep_base -= ANGLE_FULL;
        if ($urandom_range(0, 7) == 0 && sweep_base + ANGLE_FULL <= 32767)
            return 15'(sweep_base + ANGLE_FULL);
        return 15'(sweep_base);
    endfunction

    // Mostly inside the window and under the show limit, with edges and raw noise.
    function automatic logic [15:0] pick_distance();
        int lo;
        int hi;
        int top;
        int r;
        lo  = DIST_SCALE * int'(min_cm);
        hi  = DIST_SCALE * int'(max_cm);
        if (hi > 65535)
            hi = 65535;
        top = DIST_SCALE * int'(show_cm);
        if (top > hi)
            top = hi;
        r = $urandom_range(0, 9);
        if (lo > hi || r == 0)
            return 16'($urandom_range(0, 65535));
        if (r < 6 && top >= lo)
            return 16'($urandom_range(lo, top));
        if (r == 6)
            return 16'(lo);
        if (r == 7)
            return 16'(hi);
        if (r == 8)
            return 16'((hi < 65535) ? hi + 1 : lo);
        return 16'($urandom_range(lo, hi));
    endfunction

    // Random samples in bursts. hold_at starts the sink hold-off with the sender still
    // pushing; drain_at makes the sender wait for every owed beat mid-phase.
    task automatic run_phase(input int n_items, input bit gappy, input int hold_at,
                             input int drain_at);
        int          burst;
        int          gap;
        int          kind;
        logic [14:0] ang;
        logic [15:0] distance;
        burst = 0;
        for (int k = 0; k < n_items; k++)
        begin
            if (k == hold_at)
            begin
                hold_req = 1'b1;
                burst    = 40;
            end
            else if (k == drain_at)
                drain_block();
            else if (gappy && burst == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst = $urandom_range(1, 24);
            end
            if (burst > 0)
                burst--;

            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                ang      = sweep_angle();
                distance = pick_distance();
            end
            else if (kind < 90)
            begin
                ang      = sweep_angle();
                distance = 16'($urandom_range(0, 65535));
            end
            else
            begin
                ang      = 15'($urandom_range(0, 32767));
                distance = 16'($urandom_range(0, 65535));
            end
            offer_sample(ang, distance, 1'b0, QUIET);
        end
    endtask

    // ---------------------------------------------------------------- sink
    // Ready in random-length runs, or always without sink_stalls; a hold-off drops it for long.
    initial
    begin : sink
        int run;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!sink_stalls)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                run = $urandom_range(0, 8);
                if (run > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (run) @(posedge clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------- main sequence
    initial
    begin : main_seq
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples at reset settings
        for (int r = 0; r < N_ROWS; r++)
            offer_sample(DIRECTED[r].ang, DIRECTED[r].distance, DIRECTED[r].typed,
                         DIRECTED[r].want);
        drain_block();

        // random phases, each under its own register setting and idling mix;
        // phase 7 runs with no idling on either side
        for (int p = 0; p < 9; p++)
        begin
            configure(p);
            sink_stalls = (p % 3 != 1) && (p != 7);
            run_phase((p == 1) ? 40 : 175, (p != 2) && (p != 7),
                      (p == 3) ? 30 : -1, (p == 4) ? 80 : -1);
            drain_block();
        end

        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
